// ----- rtl/efrc_pkg.sv -----
package efrc_pkg;

	// Result status codes
	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_SHORT     = 3'd1,
		ST_LONG      = 3'd2,
		ST_ADDR_MISS = 3'd3,
		ST_FCS_BAD   = 3'd4
	} status_t;

	// Register indexes on the config port (byte address = 8 * index)
	typedef enum logic [1:0] {
		REG_STATION = 2'd0,
		REG_MIN_LEN = 2'd1,
		REG_MAX_LEN = 2'd2,
		REG_NONE    = 2'd3
	} reg_idx_t;

	localparam int unsigned LEN_W = 11;
	localparam logic [LEN_W-1:0] COUNT_MAX = 11'd2047;
	localparam logic [LEN_W-1:0] HDR_FCS_BYTES = 11'd18;

	localparam logic [47:0] STATION_RST = 48'h4223_52b5_a6c3;
	localparam logic [LEN_W-1:0] MIN_LEN_RST = 11'd64;
	localparam logic [LEN_W-1:0] MAX_LEN_RST = 11'd1518;

	localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
	localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

	// Reflected CRC-32, one byte
	function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] c;
		c = crc ^ {24'd0, b};
		for (int k = 0; k < 8; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

// ----- rtl/efrc_if.sv -----
// Byte stream channel
interface efrc_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;

	modport source (output valid, output data_byte, output last_byte, input ready);
	modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

// Frame result channel
interface efrc_result_if;
	logic        valid;
	logic        ready;
	logic [2:0]  frame_status;
	logic [15:0] type_field;
	logic [10:0] payload_length;

	modport source (output valid, output frame_status, output type_field,
		output payload_length, input ready);
	modport sink   (input valid, input frame_status, input type_field,
		input payload_length, output ready);
endinterface

// ----- rtl/ethernet_frame_rx_checker.sv -----
// Ethernet receive frame checker.
// byte_ch carries one frame byte per item (destination address first) with
// last_byte set on the final FCS byte. result_ch carries one item per frame:
// status, type bytes and payload length, issued after the last byte.
// Each byte is registered at the input (_s1); from that stage it updates the
// running count, address match, type capture, four-byte tail and byte-wise
// CRC-32 and, for the last byte, loads the result register.
// Throughput: one byte per cycle while no last byte waits on a held result.
// When result_ch stalls, a held result blocks only a following last byte in
// the input stage; ordinary bytes keep flowing, so at most one byte plus the
// held result are buffered before byte_ch.ready drops.
// Reset clears the frame state and both valid flags, and loads the registers
// with station address 42:23:52:b5:a6:c3, min length 64, max length 1518.
// Config: APB, 64-bit data, register i at byte address 8*i; pready is always
// high. Write registers only while no frame is in flight.
module ethernet_frame_rx_checker
	import efrc_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	efrc_byte_if.sink            byte_ch,
	efrc_result_if.source        result_ch,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [4:0]           paddr,
	input  logic [63:0]          pwdata,
	output logic [63:0]          prdata,
	output logic                 pready
);

	// Config registers
	logic [47:0]      station_q;
	logic [LEN_W-1:0] min_len_q;
	logic [LEN_W-1:0] max_len_q;
	reg_idx_t         reg_idx;

	assign pready  = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[4:3]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			station_q <= STATION_RST;
			min_len_q <= MIN_LEN_RST;
			max_len_q <= MAX_LEN_RST;
		end else if (psel && penable && pwrite && pready) begin
			unique case (reg_idx)
				REG_STATION: station_q <= pwdata[47:0];
				REG_MIN_LEN: min_len_q <= pwdata[LEN_W-1:0];
				REG_MAX_LEN: max_len_q <= pwdata[LEN_W-1:0];
				default: ;
			endcase
		end
	end

	// Read back
	always_comb begin
		unique case (reg_idx)
			REG_STATION: prdata = {16'd0, station_q};
			REG_MIN_LEN: prdata = {53'd0, min_len_q};
			REG_MAX_LEN: prdata = {53'd0, max_len_q};
			default:     prdata = 64'd0;
		endcase
	end

	// Input stage
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;
	logic       adv;

	// A last byte can move on only when the result register is free
	assign adv           = valid_s1 && (!last_s1 || !result_ch.valid || result_ch.ready);
	assign byte_ch.ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_ch.ready) begin
			valid_s1 <= byte_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_ch.valid && byte_ch.ready) begin
			byte_s1 <= byte_ch.data_byte;
			last_s1 <= byte_ch.last_byte;
		end
	end

	// Frame state
	logic [31:0]      crc_q;
	logic [LEN_W-1:0] count_q;
	logic             addr_ok_q;
	logic [31:0]      tail_q;
	logic [15:0]      type_q;

	logic [31:0]      crc_nx;
	logic [LEN_W-1:0] count_nx;
	logic             addr_ok_nx;
	logic [31:0]      tail_nx;
	logic [15:0]      type_nx;
	logic [7:0]       want_byte;
	logic [31:0]      fcs_rx;
	logic [31:0]      fcs_calc;
	status_t          status_nx;
	logic [LEN_W-1:0] payload_nx;

	// Expected destination byte at the current position
	always_comb begin
		case (count_q)
			11'd0:   want_byte = station_q[47:40];
			11'd1:   want_byte = station_q[39:32];
			11'd2:   want_byte = station_q[31:24];
			11'd3:   want_byte = station_q[23:16];
			11'd4:   want_byte = station_q[15:8];
			default: want_byte = station_q[7:0];
		endcase
	end

	// Per-byte update
	always_comb begin
		addr_ok_nx = addr_ok_q;
		if (count_q < 11'd6 && want_byte != byte_s1) begin
			addr_ok_nx = 1'b0;
		end
		type_nx = type_q;
		if (count_q == 11'd12) begin
			type_nx[7:0] = byte_s1;
		end else if (count_q == 11'd13) begin
			type_nx[15:8] = byte_s1;
		end
		// CRC lags the stream by four bytes so the FCS stays out of it
		crc_nx   = (count_q >= 11'd4) ? crc_byte(crc_q, tail_q[31:24]) : crc_q;
		tail_nx  = {tail_q[23:0], byte_s1};
		count_nx = (count_q < COUNT_MAX) ? count_q + 11'd1 : count_q;
	end

	// End-of-frame checks
	assign fcs_rx   = {tail_nx[7:0], tail_nx[15:8], tail_nx[23:16], tail_nx[31:24]};
	assign fcs_calc = ~crc_nx;

	always_comb begin
		if (count_nx < min_len_q) begin
			status_nx = ST_SHORT;
		end else if (count_nx > max_len_q) begin
			status_nx = ST_LONG;
		end else if (!addr_ok_nx) begin
			status_nx = ST_ADDR_MISS;
		end else if (fcs_rx != fcs_calc) begin
			status_nx = ST_FCS_BAD;
		end else begin
			status_nx = ST_OK;
		end
		payload_nx = (count_nx >= HDR_FCS_BYTES) ? count_nx - HDR_FCS_BYTES : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q     <= CRC_INIT;
			count_q   <= '0;
			addr_ok_q <= 1'b1;
			tail_q    <= '0;
			type_q    <= '0;
		end else if (adv) begin
			if (last_s1) begin
				crc_q     <= CRC_INIT;
				count_q   <= '0;
				addr_ok_q <= 1'b1;
				tail_q    <= '0;
				type_q    <= '0;
			end else begin
				crc_q     <= crc_nx;
				count_q   <= count_nx;
				addr_ok_q <= addr_ok_nx;
				tail_q    <= tail_nx;
				type_q    <= type_nx;
			end
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_ch.valid <= 1'b0;
		end else if (adv && last_s1) begin
			result_ch.valid <= 1'b1;
		end else if (result_ch.ready) begin
			result_ch.valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && last_s1) begin
			result_ch.frame_status   <= status_nx;
			result_ch.type_field     <= type_nx;
			result_ch.payload_length <= payload_nx;
		end
	end

	// Checks
	a_result_from_last: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_ch.valid) |-> $past(valid_s1 && last_s1))
		else $error("result raised without a last byte");

	a_restart_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && last_s1) |=> (count_q == '0 && crc_q == CRC_INIT && addr_ok_q))
		else $error("frame state not restarted after last byte");

	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_ch.valid |-> (result_ch.frame_status <= ST_FCS_BAD))
		else $error("status code out of range");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(result_ch.valid && !result_ch.ready) |-> !(adv && last_s1))
		else $error("held result overwritten");

endmodule

// ----- bench/testbench.sv -----
module testbench
	import efrc_pkg::*;
;

	timeunit 1ns;
	timeprecision 1ps;

	// How a stimulus frame is filled
	typedef enum {
		FK_GOOD,      // own destination, correct FCS
		FK_BAD_FCS,   // own destination, one FCS bit flipped
		FK_BAD_DEST,  // one destination byte wrong, FCS recomputed
		FK_NOISE,     // random bytes throughout
		FK_ZEROS,     // every byte 0x00
		FK_ONES       // every byte 0xff
	} frame_kind_e;

	typedef struct packed {
		status_t     status;
		logic [15:0] type_field;
		logic [10:0] payload_length;
	} frame_res_t;

	// Per-frame note: a typed-in result replaces the predicted one
	typedef struct {
		bit         typed;
		frame_res_t res;
	} frame_tag_t;

	typedef struct {
		int          len;
		frame_kind_e kind;
		bit          reconf;
		logic [47:0] station;
		logic [10:0] min_len;
		logic [10:0] max_len;
		bit          typed;
		status_t     status;
		logic [15:0] type_field;
		logic [10:0] payload_length;
	} dir_row_t;

	localparam logic [31:0] FCS_POLY = 32'hEDB8_8320;
	localparam int RANDOM_BYTES = 900;
	localparam int PHASES = 6;

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [4:0] paddr;
	logic [63:0] pwdata;
	logic [63:0] prdata;
	logic pready;

	efrc_byte_if byte_ch();
	efrc_result_if result_ch();

	ethernet_frame_rx_checker dut (
		.clk(clk),
		.arst_n(arst_n),
		.byte_ch(byte_ch),
		.result_ch(result_ch),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	// Predictor copy of the registers
	logic [47:0] station_q = 48'h4223_52b5_a6c3;
	logic [10:0] min_len_q = 11'd64;
	logic [10:0] max_len_q = 11'd1518;

	// Predictor copy of the per-frame state
	logic [31:0] crc_acc = 32'hFFFF_FFFF;
	logic [10:0] rx_count = '0;
	bit          dest_ok = 1'b1;
	logic [31:0] tail_q = '0;
	logic [15:0] type_q = '0;

	frame_res_t pending[$];
	frame_tag_t frame_tags[$];
	int mismatches = 0;
	int unsigned cyc = 0;
	logic steady;

	// No random idling on either side in this window
	assign steady = (cyc >= 4000) && (cyc < 7000);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	always @(posedge clk) begin
		cyc <= cyc + 1;
	end

	// Result-side backpressure
	always @(posedge clk) begin
		result_ch.ready <= steady || ($urandom_range(99) >= 13);
	end

	// Reflected CRC-32, data bits fed LSB first
	function automatic logic [31:0] crc32_step(input logic [31:0] c, input logic [7:0] d);
		logic [31:0] r;
		r = c;
		for (int i = 0; i < 8; i++) begin
			r = (r >> 1) ^ ((r[0] ^ d[i]) ? FCS_POLY : 32'd0);
		end
		return r;
	endfunction

	// Advance the frame state by one byte; returns 1 with the frame result on the last byte
	function automatic bit frame_step(input logic [7:0] b, input logic last,
		output frame_res_t res);
		logic [10:0] len;
		logic [31:0] got;
		logic [31:0] want;
		res = '0;
		if (rx_count < 6) begin
			if (b != station_q[8*(5-rx_count) +: 8]) begin
				dest_ok = 1'b0;
			end
		end
		if (rx_count == 12) begin
			type_q[7:0] = b;
		end else if (rx_count == 13) begin
			type_q[15:8] = b;
		end
		// CRC lags four bytes behind so the FCS itself stays out
		if (rx_count >= 4) begin
			crc_acc = crc32_step(crc_acc, tail_q[31:24]);
		end
		tail_q = {tail_q[23:0], b};
		if (rx_count != 11'h7ff) begin
			rx_count = rx_count + 11'd1;
		end
		if (!last) begin
			return 1'b0;
		end
		len = rx_count;
		want = ~crc_acc;
		got = {tail_q[7:0], tail_q[15:8], tail_q[23:16], tail_q[31:24]};
		if (len < min_len_q) begin
			res.status = ST_SHORT;
		end else if (len > max_len_q) begin
			res.status = ST_LONG;
		end else if (!dest_ok) begin
			res.status = ST_ADDR_MISS;
		end else if (got != want) begin
			res.status = ST_FCS_BAD;
		end else begin
			res.status = ST_OK;
		end
		res.type_field = type_q;
		res.payload_length = (len >= 11'd18) ? len - 11'd18 : 11'd0;
		crc_acc = 32'hFFFF_FFFF;
		rx_count = '0;
		dest_ok = 1'b1;
		tail_q = '0;
		type_q = '0;
		return 1'b1;
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] got,
		input logic [63:0] want);
		$display("%0t ERROR %s: got %0h expected %0h", $time, what, got, want);
		mismatches++;
	endtask

	// Byte monitor feeds the predictor; result monitor checks in order
	always @(posedge clk) begin : monitors
		frame_res_t r;
		frame_tag_t t;
		if (arst_n === 1'b1) begin
			if (byte_ch.valid && byte_ch.ready) begin
				if (frame_step(byte_ch.data_byte, byte_ch.last_byte, r)) begin
					t.typed = 1'b0;
					if (frame_tags.size() != 0) begin
						t = frame_tags.pop_front();
					end
					pending.push_back(t.typed ? t.res : r);
				end
			end
			if (result_ch.valid && result_ch.ready) begin
				if (pending.size() == 0) begin
					report_mismatch("result with no frame pending",
						result_ch.frame_status, 0);
				end else begin
					r = pending.pop_front();
					if (result_ch.frame_status !== r.status) begin
						report_mismatch("frame_status", result_ch.frame_status, r.status);
					end
					if (result_ch.type_field !== r.type_field) begin
						report_mismatch("type_field", result_ch.type_field, r.type_field);
					end
					if (result_ch.payload_length !== r.payload_length) begin
						report_mismatch("payload_length", result_ch.payload_length,
							r.payload_length);
					end
				end
			end
		end
	end

	// APB write, then read back for the real registers
	task automatic reg_write(input reg_idx_t idx, input logic [63:0] val);
		logic [63:0] got;
		logic [63:0] want;
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 3'b000};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		case (idx)
			REG_STATION: station_q = val[47:0];
			REG_MIN_LEN: min_len_q = val[10:0];
			REG_MAX_LEN: max_len_q = val[10:0];
			default: ;
		endcase
		if (idx != REG_NONE) begin
			@(posedge clk);
			psel <= 1'b1;
			pwrite <= 1'b0;
			@(posedge clk);
			penable <= 1'b1;
			@(posedge clk);
			got = prdata;
			psel <= 1'b0;
			penable <= 1'b0;
			case (idx)
				REG_STATION: want = {16'd0, station_q};
				REG_MIN_LEN: want = {53'd0, min_len_q};
				default: want = {53'd0, max_len_q};
			endcase
			if (got !== want) begin
				report_mismatch("register readback", got, want);
			end
		end
	endtask

	// Let every frame in flight finish before touching registers
	task automatic wait_idle(input int tail_cycles);
		byte_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending.size() != 0 || frame_tags.size() != 0) begin
			@(posedge clk);
		end
		repeat (tail_cycles) @(posedge clk);
	endtask

	// Upper bits carry junk to check the register masking
	task automatic set_config(input logic [47:0] sta, input logic [10:0] mn,
		input logic [10:0] mx);
		wait_idle(4);
		reg_write(REG_STATION, {16'($urandom), sta});
		reg_write(REG_MIN_LEN, {32'($urandom), 21'($urandom), mn});
		reg_write(REG_MAX_LEN, {32'($urandom), 21'($urandom), mx});
		reg_write(REG_NONE, {$urandom, $urandom});
	endtask

	// Build one frame and push it byte by byte with random gaps outside the steady window
	task automatic send_frame(input int len, input frame_kind_e kind, input frame_tag_t tag);
		logic [7:0] f[$];
		logic [31:0] c;
		int k;
		for (int i = 0; i < len; i++) begin
			case (kind)
				FK_ZEROS: f.push_back(8'h00);
				FK_ONES: f.push_back(8'hff);
				FK_NOISE: f.push_back(8'($urandom));
				default: f.push_back((i < 6) ? station_q[8*(5-i) +: 8] : 8'($urandom));
			endcase
		end
		if (kind == FK_BAD_DEST) begin
			k = $urandom_range(((len < 6) ? len : 6) - 1);
			f[k] = f[k] ^ 8'($urandom_range(1, 255));
		end
		// FCS over all but the last four bytes, low byte first
		if (kind == FK_GOOD || kind == FK_BAD_DEST || kind == FK_BAD_FCS) begin
			c = 32'hFFFF_FFFF;
			for (int i = 0; i < len - 4; i++) begin
				c = crc32_step(c, f[i]);
			end
			c = ~c;
			for (int j = 0; j < 4; j++) begin
				if (len - 4 + j >= 0) begin
					f[len-4+j] = c[8*j +: 8];
				end
			end
		end
		if (kind == FK_BAD_FCS) begin
			k = len - 1 - $urandom_range((len < 4) ? len - 1 : 3);
			f[k] = f[k] ^ 8'(1 << $urandom_range(7));
		end
		frame_tags.push_back(tag);
		for (int i = 0; i < len; i++) begin
			while (!steady && $urandom_range(99) < 13) begin
				byte_ch.valid <= 1'b0;
				@(posedge clk);
			end
			byte_ch.valid <= 1'b1;
			byte_ch.data_byte <= f[i];
			byte_ch.last_byte <= (i == len - 1);
			do begin
				@(posedge clk);
			end while (!byte_ch.ready);
		end
	endtask

	initial begin : stimulus
		dir_row_t dir_rows[];
		frame_tag_t tag;
		frame_kind_e kind;
		logic [47:0] sta;
		logic [10:0] mn;
		logic [10:0] mx;
		int sent;
		int len;
		int r;

		arst_n = 1'b0;
		byte_ch.valid = 1'b0;
		byte_ch.data_byte = '0;
		byte_ch.last_byte = 1'b0;
		result_ch.ready = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;

		// len, kind, reconfigure (station, min, max), typed result
		dir_rows = '{
			// reset settings
			'{1, FK_ZEROS, 0, 48'h0, 11'd0, 11'd0, 1, ST_SHORT, 16'h0000, 11'd0},
			'{14, FK_ONES, 0, 48'h0, 11'd0, 11'd0, 1, ST_SHORT, 16'hffff, 11'd0},
			'{64, FK_ZEROS, 0, 48'h0, 11'd0, 11'd0, 1, ST_ADDR_MISS, 16'h0000, 11'd46},
			'{64, FK_GOOD, 0, 48'h0, 11'd0, 11'd0, 0, ST_OK, 16'h0, 11'd0},
			'{64, FK_BAD_FCS, 0, 48'h0, 11'd0, 11'd0, 0, ST_OK, 16'h0, 11'd0},
			'{64, FK_BAD_DEST, 0, 48'h0, 11'd0, 11'd0, 0, ST_OK, 16'h0, 11'd0},
			// over the reset maximum, count saturates at 2047
			'{2048, FK_ONES, 0, 48'h0, 11'd0, 11'd0, 1, ST_LONG, 16'hffff, 11'd2029},
			// zero station, narrow window: sub-four-byte frame passes its FCS
			'{3, FK_ZEROS, 1, 48'h0, 11'd0, 11'd20, 1, ST_OK, 16'h0000, 11'd0},
			'{20, FK_GOOD, 0, 48'h0, 11'd0, 11'd20, 0, ST_OK, 16'h0, 11'd0},
			'{21, FK_GOOD, 0, 48'h0, 11'd0, 11'd20, 0, ST_OK, 16'h0, 11'd0},
			'{13, FK_ONES, 0, 48'h0, 11'd0, 11'd20, 1, ST_ADDR_MISS, 16'h00ff, 11'd0},
			// minimum above maximum
			'{60, FK_ZEROS, 1, 48'hffff_ffff_ffff, 11'd100, 11'd50, 1, ST_SHORT, 16'h0000,
				11'd42},
			'{75, FK_ONES, 0, 48'h0, 11'd0, 11'd0, 1, ST_SHORT, 16'hffff, 11'd57}
		};

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed frames
		foreach (dir_rows[i]) begin
			if (dir_rows[i].reconf) begin
				set_config(dir_rows[i].station, dir_rows[i].min_len, dir_rows[i].max_len);
			end
			tag.typed = dir_rows[i].typed;
			tag.res.status = dir_rows[i].status;
			tag.res.type_field = dir_rows[i].type_field;
			tag.res.payload_length = dir_rows[i].payload_length;
			send_frame(dir_rows[i].len, dir_rows[i].kind, tag);
		end

		// Random frames, several register settings
		tag.typed = 1'b0;
		tag.res = '0;
		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0: sta = 48'h0;
				1: sta = 48'hffff_ffff_ffff;
				default: sta = {16'($urandom), 32'($urandom)};
			endcase
			mn = (ph % 2 == 0) ? 11'd0 : 11'($urandom_range(10, 70));
			mx = (ph % 2 == 0) ? 11'd2047 : 11'($urandom_range(40, 100));
			if (ph == 4) begin
				mx = 11'd1518;
			end
			set_config(sta, mn, mx);
			sent = 0;
			while (sent < RANDOM_BYTES / PHASES) begin
				r = $urandom_range(99);
				if (r < 12) begin
					len = $urandom_range(1, 17);
				end else if (r < 90) begin
					len = $urandom_range(18, 80);
				end else begin
					len = $urandom_range(81, 300);
				end
				r = $urandom_range(99);
				kind = (r < 70) ? FK_GOOD : (r < 80) ? FK_BAD_FCS :
					(r < 90) ? FK_BAD_DEST : FK_NOISE;
				send_frame(len, kind, tag);
				sent += len;
			end
		end

		wait_idle(8);
		if (mismatches == 0) begin
			$display("ethernet_frame_rx_checker verification clean");
		end else begin
			$display("ethernet_frame_rx_checker verification failed");
		end
		$finish;
	end

	// Hang guard
	initial begin
		#2_000_000;
		$display("ethernet_frame_rx_checker verification failed");
		$finish;
	end

endmodule

// ----- filelist.f -----
rtl/efrc_pkg.sv
rtl/efrc_if.sv
rtl/ethernet_frame_rx_checker.sv
bench/testbench.sv
